### rtl/core/u8rtf_pkg.sv
// shared types, constants and helper functions of the utf-8 to rtf escape unit
package u8rtf_pkg;

	// code point and decimal conversion widths
	localparam int CP_W        = 21;
	localparam int BCD_DIGITS  = 7;
	localparam int BCD_W       = 4 * BCD_DIGITS;
	localparam int CONV_STEPS  = CP_W;
	localparam int CNT_W       = 5;
	localparam int IDX_W       = 4;
	localparam int NBUF        = 4;

	// character position within one escape sequence
	localparam logic [IDX_W-1:0] IDX_FIRST     = 4'd1;
	localparam logic [IDX_W-1:0] IDX_ESC_END   = 4'd1;
	localparam logic [IDX_W-1:0] IDX_HEX_HI    = 4'd2;
	localparam logic [IDX_W-1:0] IDX_HEX_END   = 4'd3;
	localparam logic [IDX_W-1:0] IDX_DIG_FIRST = 4'd2;
	localparam logic [IDX_W-1:0] IDX_DIG_LAST  = 4'd8;
	localparam logic [IDX_W-1:0] IDX_UNI_END   = 4'd9;

	// ascii characters used in the escapes
	localparam logic [6:0] CH_BSL  = 7'h5C;
	localparam logic [6:0] CH_APOS = 7'h27;
	localparam logic [6:0] CH_U    = 7'h75;
	localparam logic [6:0] CH_QM   = 7'h3F;
	localparam logic [6:0] CH_ZERO = 7'h30;
	localparam logic [6:0] CH_A    = 7'h41;
	localparam logic [6:0] CH_LBR  = 7'h7B;
	localparam logic [6:0] CH_RBR  = 7'h7D;

	// utf-8 byte classes: number of continuation bytes a lead claims
	localparam logic [2:0] CLS_ASCII = 3'd0;
	localparam logic [2:0] CLS_LEAD2 = 3'd1;
	localparam logic [2:0] CLS_LEAD3 = 3'd2;
	localparam logic [2:0] CLS_LEAD4 = 3'd3;
	localparam logic [2:0] CLS_BAD   = 3'd4;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_CONV   = 5'b00100,
		ST_EMIT   = 5'b01000,
		ST_FLUSH  = 5'b10000
	} state_t;

	// how a code point is written out
	typedef enum logic [1:0] {
		KIND_PLAIN = 2'd0,
		KIND_ESC   = 2'd1,
		KIND_HEX   = 2'd2,
		KIND_UNI   = 2'd3
	} kind_t;

	typedef struct packed {
		logic             load;
		logic             step;
		logic             conv_step;
		logic             put;
		logic             flush;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic  hold;
		logic  front_drop;
		kind_t front_kind;
		logic  rest_zero;
		logic  n_zero;
		logic  emit_skip;
		logic  emit_end;
		logic  put_ok;
		logic  flush_ok;
	} sts_t;

	function automatic logic [2:0] byte_class(input logic [7:0] b);
		logic [2:0] cls;
		if (b[7] == 1'b0)
			cls = CLS_ASCII;
		else if ((b & 8'hE0) == 8'hC0)
			cls = CLS_LEAD2;
		else if ((b & 8'hF0) == 8'hE0)
			cls = CLS_LEAD3;
		else if ((b & 8'hF8) == 8'hF0)
			cls = CLS_LEAD4;
		else
			cls = CLS_BAD;
		return cls;
	endfunction

	function automatic logic [6:0] hex_char(input logic [3:0] v);
		logic [6:0] c;
		if (v < 4'd10)
			c = CH_ZERO + {3'b000, v};
		else
			c = CH_A + {3'b000, v - 4'd10};
		return c;
	endfunction

	function automatic kind_t cp_kind(input logic [CP_W-1:0] cp);
		kind_t k;
		if (cp < 21'h20 || (cp >= 21'h80 && cp < 21'h100))
			k = KIND_HEX;
		else if (cp < 21'h80) begin
			if (cp[6:0] == CH_BSL || cp[6:0] == CH_LBR || cp[6:0] == CH_RBR)
				k = KIND_ESC;
			else
				k = KIND_PLAIN;
		end else
			k = KIND_UNI;
		return k;
	endfunction

endpackage

### rtl/core/u8rtf_ctrl.sv
// sequencer for item acceptance, decode, decimal conversion, emission and flush
module u8rtf_ctrl import u8rtf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.idx  = idx_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.hold ? ST_IDLE : ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.n_zero) begin
					state_d = ST_FLUSH;
				end else if (sts.front_drop) begin
					cmd.step = 1'b1;
					if (sts.rest_zero)
						state_d = ST_FLUSH;
				end else begin
					cmd.put = 1'b1;
					if (sts.put_ok) begin
						cmd.step = 1'b1;
						case (sts.front_kind)
							KIND_PLAIN: begin
								if (sts.rest_zero)
									state_d = ST_FLUSH;
							end
							KIND_UNI: begin
								state_d = ST_CONV;
							end
							default: begin
								idx_d   = IDX_FIRST;
								state_d = ST_EMIT;
							end
						endcase
					end
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (cnt_q == CNT_W'(CONV_STEPS - 1)) begin
					cnt_d   = '0;
					idx_d   = IDX_FIRST;
					state_d = ST_EMIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (sts.emit_skip) begin
					idx_d = idx_q + 1'b1;
				end else begin
					cmd.put = 1'b1;
					if (sts.put_ok) begin
						if (sts.emit_end) begin
							idx_d   = '0;
							state_d = sts.n_zero ? ST_FLUSH : ST_DECODE;
						end else begin
							idx_d = idx_q + 1'b1;
						end
					end
				end
			end
			ST_FLUSH: begin
				if (sts.flush_ok) begin
					cmd.flush = 1'b1;
					in_stall  = 1'b0;
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = sts.hold ? ST_IDLE : ST_DECODE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
		end
	end

`ifndef NO_ASSERTIONS
	// conversion counter only runs during the conversion
	a_cnt_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> state_q == ST_CONV)
		else $error("conversion counter active outside conversion");

	// escape position is zero outside emission and nonzero inside
	a_idx_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != '0) == (state_q == ST_EMIT))
		else $error("escape position out of step with emission");

	// flush is only reached from decode or emission
	a_flush_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> $past(state_q) == ST_DECODE
			|| $past(state_q) == ST_EMIT || $past(state_q) == ST_FLUSH)
		else $error("flush entered from an unexpected state");
`endif

endmodule

### rtl/core/u8rtf_dp.sv
// byte buffer, code point decode, decimal conversion, pending and output registers
module u8rtf_dp import u8rtf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       out_stall,
	input  cmd_t       cmd,
	output sts_t       sts,
	output logic       out_valid,
	output logic [6:0] out_char,
	output logic       char_valid,
	output logic       out_last
);

	// byte buffer: held sequence bytes plus the current item, front at entry zero
	logic [7:0]       wb_q [NBUF];
	logic [1:0]       hc_q;
	logic [1:0]       nd_q;
	logic [2:0]       n_q;
	logic             last_q;

	logic [CP_W-1:0]  cp_q;
	kind_t            kind_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] bcd_adj;

	logic             pend_valid_q;
	logic [6:0]       pend_char_q;
	logic             out_valid_q;
	logic [6:0]       out_char_q;
	logic             out_cv_q;
	logic             out_last_q;

	logic [2:0]       cls_in;
	logic             hold;
	logic [2:0]       cls0;
	logic             front_lead;
	logic             front_drop;
	logic [2:0]       consume;
	logic [CP_W-1:0]  front_cp;
	kind_t            front_kind;

	logic [2:0]       dsel;
	logic [3:0]       digit;
	logic [BCD_DIGITS:0] hz;
	logic             emit_skip;
	logic             emit_end;
	logic [6:0]       ch;

	logic             out_free;
	logic             put_ok;
	logic             do_put;
	logic             flush_push;
	logic             push;

	// hold decision for the incoming byte
	always_comb begin
		cls_in = byte_class(in_byte);
		hold   = 1'b0;
		if (!in_last) begin
			if (hc_q == 2'd0)
				hold = (cls_in == CLS_LEAD2 || cls_in == CLS_LEAD3 || cls_in == CLS_LEAD4);
			else
				hold = (hc_q < nd_q);
		end
	end

	// decode of the sequence at the buffer front
	always_comb begin
		cls0       = byte_class(wb_q[0]);
		front_lead = (cls0 == CLS_LEAD2 || cls0 == CLS_LEAD3 || cls0 == CLS_LEAD4)
			&& (cls0 < n_q);
		front_drop = (cls0 != CLS_ASCII) && !front_lead;
		consume    = front_lead ? cls0 + 3'd1 : 3'd1;
		case (cls0)
			CLS_LEAD2: front_cp = {10'b0, wb_q[0][4:0], wb_q[1][5:0]};
			CLS_LEAD3: front_cp = {5'b0, wb_q[0][3:0], wb_q[1][5:0], wb_q[2][5:0]};
			CLS_LEAD4: front_cp = {wb_q[0][2:0], wb_q[1][5:0], wb_q[2][5:0], wb_q[3][5:0]};
			default:   front_cp = {13'b0, wb_q[0]};
		endcase
		front_kind = cp_kind(front_cp);
	end

	// decimal digit selection and leading zero detection
	always_comb begin
		dsel  = 3'(IDX_DIG_LAST - cmd.idx);
		digit = '0;
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if (dsel == 3'(d))
				digit = bcd_q[4*d +: 4];
		end
		hz[BCD_DIGITS] = 1'b1;
		for (int d = BCD_DIGITS - 1; d >= 0; d--)
			hz[d] = hz[d+1] && (bcd_q[4*d +: 4] == 4'd0);
		emit_skip = (kind_q == KIND_UNI) && (cmd.idx >= IDX_DIG_FIRST)
			&& (cmd.idx < IDX_DIG_LAST) && hz[dsel];
	end

	// last character position of each escape
	always_comb begin
		case (kind_q)
			KIND_ESC: emit_end = (cmd.idx == IDX_ESC_END);
			KIND_HEX: emit_end = (cmd.idx == IDX_HEX_END);
			KIND_UNI: emit_end = (cmd.idx == IDX_UNI_END);
			default:  emit_end = 1'b1;
		endcase
	end

	// character to put
	always_comb begin
		if (cmd.idx == '0) begin
			ch = (front_kind == KIND_PLAIN) ? front_cp[6:0] : CH_BSL;
		end else begin
			case (kind_q)
				KIND_HEX: begin
					if (cmd.idx == IDX_FIRST)
						ch = CH_APOS;
					else if (cmd.idx == IDX_HEX_HI)
						ch = hex_char(cp_q[7:4]);
					else
						ch = hex_char(cp_q[3:0]);
				end
				KIND_UNI: begin
					if (cmd.idx == IDX_FIRST)
						ch = CH_U;
					else if (cmd.idx == IDX_UNI_END)
						ch = CH_QM;
					else
						ch = CH_ZERO + {3'b000, digit};
				end
				default: begin
					ch = cp_q[6:0];
				end
			endcase
		end
	end

	// double dabble correction
	always_comb begin
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5)
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			else
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4];
		end
	end

	// output handshake
	assign out_free   = !out_valid_q || !out_stall;
	assign put_ok     = !pend_valid_q || out_free;
	assign do_put     = cmd.put && put_ok;
	assign flush_push = cmd.flush && (pend_valid_q || last_q);
	assign push       = (do_put && pend_valid_q) || flush_push;

	always_comb begin
		sts            = '0;
		sts.hold       = hold;
		sts.front_drop = front_drop;
		sts.front_kind = front_kind;
		sts.rest_zero  = (n_q == consume);
		sts.n_zero     = (n_q == 3'd0);
		sts.emit_skip  = emit_skip;
		sts.emit_end   = emit_end;
		sts.put_ok     = put_ok;
		sts.flush_ok   = !(pend_valid_q || last_q) || out_free;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q         <= '0;
			nd_q         <= '0;
			n_q          <= '0;
			last_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (hold) begin
					hc_q <= hc_q + 2'd1;
					if (hc_q == 2'd0)
						nd_q <= cls_in[1:0];
				end else begin
					hc_q   <= '0;
					nd_q   <= '0;
					n_q    <= {1'b0, hc_q} + 3'd1;
					last_q <= in_last;
				end
			end else if (cmd.step) begin
				n_q <= n_q - consume;
			end
			if (do_put)
				pend_valid_q <= 1'b1;
			else if (cmd.flush)
				pend_valid_q <= 1'b0;
			if (push)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wb_q[hc_q] <= in_byte;
		end else if (cmd.step) begin
			case (consume)
				3'd1: begin
					wb_q[0] <= wb_q[1];
					wb_q[1] <= wb_q[2];
					wb_q[2] <= wb_q[3];
				end
				3'd2: begin
					wb_q[0] <= wb_q[2];
					wb_q[1] <= wb_q[3];
				end
				3'd3: begin
					wb_q[0] <= wb_q[3];
				end
				default: begin
				end
			endcase
		end
		if (cmd.step) begin
			cp_q   <= front_cp;
			kind_q <= front_kind;
			bcd_q  <= '0;
		end else if (cmd.conv_step) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], cp_q[CP_W-1]};
			cp_q  <= {cp_q[CP_W-2:0], 1'b0};
		end
		if (do_put)
			pend_char_q <= ch;
		if (push) begin
			out_char_q <= pend_valid_q ? pend_char_q : 7'd0;
			out_cv_q   <= pend_valid_q;
			out_last_q <= cmd.flush ? last_q : 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign char_valid = out_cv_q;
	assign out_last   = out_last_q;

`ifndef NO_ASSERTIONS
	// a held sequence never holds more bytes than its lead claims
	a_held_count: assert property (@(posedge clk) disable iff (!arst_n)
		hc_q != 2'd0 |-> hc_q <= nd_q)
		else $error("held byte count exceeds claimed length");
`endif

endmodule

### rtl/core/utf8_to_rtf_escape_unit.sv
// Decodes a UTF-8 byte stream one byte per item and writes it out as RTF text,
// one ASCII character per result item. A lead byte that is not the last of the
// string is held. A byte that completes a code point is decoded and its first
// character is put in the decode state; every further escape character (backslash
// prefix, \'XX, \u...?) is put in the emit state, and the flush state that closes
// the item also accepts the next item. Code points from 0x100 up first pass
// through the bit-serial binary to decimal conversion, and leading zero digits
// are skipped during emission. All of this is set by the single decode and emit
// sequencer, which works on one item at a time; stalls on the output hold it.
// A one-character pending register lets the end-of-string flag land on the
// final character, or on a bare end marker when the string ends with nothing.
module utf8_to_rtf_escape_unit import u8rtf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] out_char,
	output logic       char_valid,
	output logic       out_last
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	u8rtf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	u8rtf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_char   (out_char),
		.char_valid (char_valid),
		.out_last   (out_last)
	);

endmodule

### dv/tb_utf8_to_rtf_escape_unit.sv
// testbench for the utf-8 to rtf escape unit: directed and random strings against a predictor
module tb_utf8_to_rtf_escape_unit import u8rtf_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 80;
	localparam int REPORT_MAX   = 10;
	localparam int CONT_BAD     = 4;
	localparam string HEX_DIGITS = "0123456789ABCDEF";

	typedef struct {
		logic [6:0] ch;
		logic       valid;
		logic       last;
	} rtf_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [6:0] out_char;
	logic       char_valid;
	logic       out_last;

	// predictor state
	logic [7:0] held_seq [3];
	int         held_len = 0;
	int         claim_len = 0;
	rtf_char_t  item_chars_q [$];
	rtf_char_t  rtf_exp_q [$];

	int  mismatch_cnt = 0;
	int  cycle_cnt = 0;
	bit  no_idle = 1'b0;
	bit  rx_hold = 1'b0;
	int  rx_run_left = 0;

	utf8_to_rtf_escape_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.char_valid (char_valid),
		.out_last   (out_last)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver stalls: runs without stall, short stalls and a few long ones
	always @(posedge clk) begin
		if (rx_run_left > 0)
			rx_run_left <= rx_run_left - 1;
		else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					rx_hold <= 1'b0;
					rx_run_left <= $urandom_range(1, 30);
				end
				9: begin
					rx_hold <= 1'b1;
					rx_run_left <= $urandom_range(8, 25);
				end
				default: begin
					rx_hold <= 1'b1;
					rx_run_left <= $urandom_range(0, 2);
				end
			endcase
		end
		out_stall <= rx_hold && !no_idle;
	end

	// continuation bytes claimed by a lead, CONT_BAD for stray bytes
	function automatic int claimed_conts(input logic [7:0] b);
		int k;
		casez (b)
			8'b0???????: k = 0;
			8'b110?????: k = 1;
			8'b1110????: k = 2;
			8'b11110???: k = 3;
			default:     k = CONT_BAD;
		endcase
		return k;
	endfunction

	function automatic logic [6:0] hex_ascii(input logic [3:0] v);
		return 7'(HEX_DIGITS[v]);
	endfunction

	task automatic push_char(input logic [6:0] c);
		rtf_char_t r;
		r.ch = c;
		r.valid = 1'b1;
		r.last = 1'b0;
		item_chars_q.insert(item_chars_q.size(), r);
	endtask

	// rtf text of one code point
	task automatic escape_code_point(input int unsigned cp);
		logic [6:0] dec_q [$];
		int unsigned v;
		if (cp < 'h20 || (cp >= 'h80 && cp < 'h100)) begin
			push_char(CH_BSL);
			push_char(CH_APOS);
			push_char(hex_ascii(cp[7:4]));
			push_char(hex_ascii(cp[3:0]));
		end else if (cp < 'h80) begin
			if (cp[6:0] == CH_BSL || cp[6:0] == CH_LBR || cp[6:0] == CH_RBR)
				push_char(CH_BSL);
			push_char(cp[6:0]);
		end else begin
			push_char(CH_BSL);
			push_char(CH_U);
			v = cp;
			do begin
				dec_q.push_front(CH_ZERO + 7'(v % 10));
				v = v / 10;
			end while (v != 0);
			foreach (dec_q[j])
				push_char(dec_q[j]);
			push_char(CH_QM);
		end
	endtask

	// decode a run of up to four bytes that ends at n
	task automatic decode_run_bytes(input logic [7:0] run [4], input int n);
		int i;
		int k;
		int unsigned cp;
		i = 0;
		while (i < n) begin
			k = claimed_conts(run[i]);
			if (k == 0) begin
				escape_code_point(32'(run[i]));
				i++;
			end else if (k <= 3 && i + k < n) begin
				case (k)
					1: cp = 32'({run[i][4:0], run[i+1][5:0]});
					2: cp = 32'({run[i][3:0], run[i+1][5:0], run[i+2][5:0]});
					default: cp = 32'({run[i][2:0], run[i+1][5:0],
						run[i+2][5:0], run[i+3][5:0]});
				endcase
				escape_code_point(cp);
				i += k + 1;
			end else
				i++;
		end
	endtask

	// expected characters of one accepted item
	task automatic predict_rtf(input logic [7:0] b, input logic last);
		logic [7:0] run [4];
		int n;
		int k;
		rtf_char_t end_mark;
		n = 0;
		for (int j = 0; j < held_len; j++) begin
			run[n] = held_seq[j];
			n++;
		end
		run[n] = b;
		n++;
		if (!last) begin
			if (held_len == 0) begin
				k = claimed_conts(b);
				if (k >= 1 && k <= 3) begin
					held_seq[0] = b;
					held_len = 1;
					claim_len = k;
					return;
				end
			end else if (n < claim_len + 1) begin
				held_seq[held_len] = b;
				held_len++;
				return;
			end
		end
		item_chars_q.delete();
		decode_run_bytes(run, n);
		held_len = 0;
		claim_len = 0;
		if (last) begin
			if (item_chars_q.size() == 0) begin
				end_mark.ch = 7'h00;
				end_mark.valid = 1'b0;
				end_mark.last = 1'b1;
				item_chars_q.insert(item_chars_q.size(), end_mark);
			end else
				item_chars_q[item_chars_q.size()-1].last = 1'b1;
		end
		foreach (item_chars_q[j])
			rtf_exp_q.insert(rtf_exp_q.size(), item_chars_q[j]);
	endtask

	function automatic int idle_gap();
		int g;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: g = 0;
			9:                g = $urandom_range(6, 20);
			default:          g = $urandom_range(1, 3);
		endcase
		return g;
	endfunction

	// send one item; valid stays high when the next item follows without a gap
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = no_idle ? 0 : idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= last;
		do @(posedge clk); while (in_stall);
		predict_rtf(b, last);
	endtask

	task automatic send_string(input logic [7:0] s [$]);
		foreach (s[j])
			send_byte(s[j], j == s.size() - 1);
	endtask

	task automatic note_mismatch(input string what, input rtf_char_t exp_c);
		mismatch_cnt++;
		if (mismatch_cnt <= REPORT_MAX)
			$display("%s: exp char %h valid %b last %b, got char %h valid %b last %b",
				what, exp_c.ch, exp_c.valid, exp_c.last, out_char, char_valid, out_last);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (rtf_exp_q.size() == 0)
				note_mismatch("unexpected item", '{7'h00, 1'b0, 1'b0});
			else begin
				if (out_char !== rtf_exp_q[0].ch || char_valid !== rtf_exp_q[0].valid ||
				    out_last !== rtf_exp_q[0].last)
					note_mismatch("wrong item", rtf_exp_q[0]);
				void'(rtf_exp_q.pop_front());
			end
		end
	end

	// ascii extremes and characters that need a backslash
	task automatic test_ascii_escapes();
		send_string('{8'h00, 8'h1F, 8'h20, 8'h5C, 8'h7B, 8'h7D, 8'h41, 8'h7F});
	endtask

	// two-byte sequences around the hex and decimal boundaries, unchecked continuation
	task automatic test_two_byte();
		send_string('{8'hC2, 8'h80, 8'hC3, 8'hBF, 8'hC4, 8'h80, 8'hDF, 8'hBF, 8'hC3, 8'h41});
	endtask

	// three- and four-byte sequences up to the largest code point
	task automatic test_long_sequences();
		send_string('{8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF});
		send_string('{8'hF0, 8'h90, 8'h80, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF});
	endtask

	// stray bytes dropped, bare end marker
	task automatic test_stray_bytes();
		send_string('{8'h80, 8'hBF, 8'hF8, 8'hFF});
		send_string('{8'hC3});
	endtask

	// last byte arrives inside a sequence
	task automatic test_truncated();
		send_string('{8'hE2, 8'h41});
		send_string('{8'hF0, 8'hC3, 8'hA9});
		send_string('{8'hF0, 8'h80, 8'hE2});
	endtask

	function automatic logic [7:0] cont_byte();
		logic [7:0] c;
		if ($urandom_range(0, 7) == 0)
			c = 8'($urandom_range(0, 255));
		else
			c = 8'h80 | 8'($urandom_range(0, 63));
		return c;
	endfunction

	// strings of mostly well-formed code points with some noise and truncation
	task automatic test_random_strings(input int n_items);
		logic [7:0] s [$];
		int sent;
		int ncp;
		sent = 0;
		while (sent < n_items) begin
			s.delete();
			ncp = $urandom_range(1, 6);
			repeat (ncp) begin
				case ($urandom_range(0, 19))
					7: s.insert(s.size(), $urandom_range(0, 1) ? 8'h5C : 8'h7B);
					8: s.insert(s.size(),
						$urandom_range(0, 1) ? 8'h7D : 8'($urandom_range(0, 31)));
					9, 10, 11: begin
						s.insert(s.size(), 8'hC0 | 8'($urandom_range(0, 31)));
						s.insert(s.size(), cont_byte());
					end
					12, 13: begin
						s.insert(s.size(), 8'hE0 | 8'($urandom_range(0, 15)));
						s.insert(s.size(), cont_byte());
						s.insert(s.size(), cont_byte());
					end
					14, 15: begin
						s.insert(s.size(), 8'hF0 | 8'($urandom_range(0, 7)));
						s.insert(s.size(), cont_byte());
						s.insert(s.size(), cont_byte());
						s.insert(s.size(), cont_byte());
					end
					16, 17: s.insert(s.size(), 8'($urandom_range(0, 255)));
					18: s.insert(s.size(), 8'hC0 | 8'($urandom_range(0, 63)));
					19: s.insert(s.size(), 8'hF0 | 8'($urandom_range(0, 15)));
					default: s.insert(s.size(), 8'($urandom_range(0, 127)));
				endcase
			end
			// cut the string short so it may end inside a sequence
			if (s.size() > 1 && $urandom_range(0, 4) == 0)
				s = s[0:$urandom_range(0, s.size() - 1)];
			send_string(s);
			sent += s.size();
		end
	endtask

	// back to back with no idling on either side
	task automatic test_no_idle();
		no_idle = 1'b1;
		test_random_strings(35);
		no_idle = 1'b0;
	endtask

	// test sequence and final verdict
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ascii_escapes();
		test_two_byte();
		test_long_sequences();
		test_stray_bytes();
		test_truncated();
		test_random_strings(65);
		test_no_idle();
		in_valid <= 1'b0;
		while (rtf_exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && rtf_exp_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
